// File: sv/lbfs_pkg.sv
// ----------------------------------------------------------------------------
// lbfs_pkg
// Shared widths, word types and helpers for the bidiagonal forward solver.
// ----------------------------------------------------------------------------
package lbfs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_W      = 2 * DATA_WIDTH;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] diag;
        logic signed [DATA_WIDTH-1:0] sub_diag;
        logic signed [DATA_WIDTH-1:0] rhs;
        logic                         first_row;
        logic                         last_row;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] solution;
        logic                         zero_divisor;
        logic                         saturated;
        logic                         last_out;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] raw);
        mag_of = raw[DATA_WIDTH-1] ? (~raw + 1'b1) : raw;
    endfunction

endpackage

// File: sv/lbfs_mul.sv
// ----------------------------------------------------------------------------
// lbfs_mul
// Registered unsigned magnitude multiplier, full double-width product.
// ----------------------------------------------------------------------------
module lbfs_mul
    import lbfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic [NUM_W-1:0]      o_prod
);

    logic [NUM_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= NUM_W'(i_a) * NUM_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: sv/lbfs_div.sv
// ----------------------------------------------------------------------------
// lbfs_div
// Restoring shift-subtract divider, one quotient bit per cycle. The caller
// guarantees the upper numerator half is below the divisor.
// ----------------------------------------------------------------------------
module lbfs_div
    import lbfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    output t_div_stat             o_stat,
    output logic [DATA_WIDTH-1:0] o_quot
);

    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_lo;
    logic [DATA_WIDTH-1:0] r_den;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DATA_WIDTH:0]   n_trial;
    logic                  n_ge;
    logic [DATA_WIDTH:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_lo[DATA_WIDTH-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= n_ge ? n_diff[DATA_WIDTH-1:0] : n_trial[DATA_WIDTH-1:0];
                r_lo  <= {r_lo[DATA_WIDTH-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_rem  <= i_num[NUM_W-1:DATA_WIDTH];
                r_lo   <= i_num[DATA_WIDTH-1:0];
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_lo;

endmodule

// File: sv/lower_bidiagonal_forward_solve_core.sv
// ----------------------------------------------------------------------------
// lower_bidiagonal_forward_solve_core
// Forward substitution for a lower bidiagonal system, one row per word.
// ----------------------------------------------------------------------------
// Each accepted row word yields one solution word,
// x = (rhs - sub_diag * x_prev) / diag in signed Q16.16, truncated toward
// zero and saturated to the 32-bit range. A normal row passes from
// acceptance through the multiply, numerator and check states and the
// shift-subtract divider to the finish state, which waits while the output
// register is still full; the next row is accepted after it. A zero diagonal
// or an overflowing quotient skips the divider. The result sits in an output
// register, so the next row may be accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module lower_bidiagonal_forward_solve_core
    import lbfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_NUM  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [DATA_WIDTH-1:0] TOP = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [2:0]            r_state;
    logic [DATA_WIDTH-1:0] r_dm, r_sm, r_rm, r_pm, r_prev;
    logic                  r_dn, r_sn, r_rn, r_pn, r_first, r_last;
    logic [NUM_W-1:0]      r_num;
    logic                  r_numneg;
    logic                  r_ovf;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic [NUM_W-1:0]      w_prod;
    t_div_stat             w_div;
    logic [DATA_WIDTH-1:0] w_quot;

    logic [NUM_W-1:0]      n_a, n_b, n_num;
    logic                  n_bneg, n_numneg;
    logic                  n_ovf, n_zdiv, n_start;
    logic                  n_negres, n_sat;
    logic [DATA_WIDTH-1:0] n_res;
    logic                  n_load;

    lbfs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (r_sm),
        .i_b    (r_pm),
        .o_prod (w_prod)
    );

    lbfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_num   (r_num),
        .i_den   (r_dm),
        .o_stat  (w_div),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_a    = NUM_W'(r_rm) << FRAC_BITS;
        n_b    = r_first ? '0 : w_prod;
        n_bneg = !r_first && (r_sn ^ r_pn);
        if (r_rn != n_bneg) begin
            n_num    = n_a + n_b;
            n_numneg = r_rn;
        end else if (n_a >= n_b) begin
            n_num    = n_a - n_b;
            n_numneg = r_rn;
        end else begin
            n_num    = n_b - n_a;
            n_numneg = !r_rn;
        end
        if (n_num == '0) begin
            n_numneg = 1'b0;
        end
    end

    always_comb begin
        n_zdiv  = r_dm == '0;
        n_ovf   = r_num[NUM_W-1:DATA_WIDTH] >= r_dm;
        n_start = (r_state == S_CHK) && !n_zdiv && !n_ovf;
        n_load  = (r_state == S_FIN) && (!r_out_valid || i_ready);
    end

    always_comb begin
        n_negres = 1'b0;
        n_sat    = 1'b1;
        n_res    = '0;
        if (n_zdiv) begin
            n_res = r_numneg ? TOP : TOP - 1'b1;
        end else if (r_ovf) begin
            n_negres = r_numneg ^ r_dn;
            n_res    = n_negres ? TOP : TOP - 1'b1;
        end else begin
            n_negres = (r_numneg ^ r_dn) && (w_quot != '0);
            n_sat    = w_quot > (n_negres ? TOP : TOP - 1'b1);
            if (n_sat) begin
                n_res = n_negres ? TOP : TOP - 1'b1;
            end else begin
                n_res = n_negres ? (~w_quot + 1'b1) : w_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (r_out_valid && i_ready && !n_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dm    <= mag_of(i_data.diag);
                        r_sm    <= mag_of(i_data.sub_diag);
                        r_rm    <= mag_of(i_data.rhs);
                        r_pm    <= mag_of(r_prev);
                        r_dn    <= i_data.diag[DATA_WIDTH-1];
                        r_sn    <= i_data.sub_diag[DATA_WIDTH-1];
                        r_rn    <= i_data.rhs[DATA_WIDTH-1];
                        r_pn    <= r_prev[DATA_WIDTH-1];
                        r_first <= i_data.first_row;
                        r_last  <= i_data.last_row;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num    <= n_num;
                    r_numneg <= n_numneg;
                    r_state  <= S_CHK;
                end
                S_CHK: begin
                    r_ovf   <= n_ovf;
                    r_state <= n_start ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_load) begin
                        r_out.solution     <= n_res;
                        r_out.zero_divisor <= n_zdiv;
                        r_out.saturated    <= n_sat;
                        r_out.last_out     <= r_last;
                        r_out_valid        <= 1'b1;
                        r_prev             <= n_res;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_div.busy)
        else $error("ready while divider busy");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divider done outside divide state");

    a_zdiv_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_divisor |-> o_data.saturated)
        else $error("zero divisor without saturation");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

endmodule

// File: tb/lower_bidiagonal_forward_solve_core_test.sv
// ----------------------------------------------------------------------------
// lower_bidiagonal_forward_solve_core_test
// Self-checking bench for the bidiagonal forward solver.
// A short table of hand-picked rows runs first: extremes, zero diagonals,
// overflow in both directions and truncation. Random systems and noise rows
// follow. Each solution word is checked against its table value if given,
// else an in-bench fixed-point solver, with random gaps and stalls on both
// sides and one long output stall that backs the core up.
// ----------------------------------------------------------------------------
module lower_bidiagonal_forward_solve_core_test
    import lbfs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ROWS   = 1280;
    localparam int TAIL_CYCLES = 60;

    localparam logic [DATA_WIDTH-1:0] ONE   = 32'h0001_0000;
    localparam logic [DATA_WIDTH-1:0] W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic signed [NUM_W+1:0] Q_MAX = (66'sd1 <<< (DATA_WIDTH-1)) - 66'sd1;
    localparam logic signed [NUM_W+1:0] Q_MIN = -(66'sd1 <<< (DATA_WIDTH-1));

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word sol;
    } t_table_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_word  i_data  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_data;

    logic signed [DATA_WIDTH-1:0] x_prev = '0;
    t_out_word sol_q[$];

    int  errors     = 0;
    int  checked    = 0;
    int  zdiv_seen  = 0;
    int  sat_seen   = 0;
    int  rows_sent  = 0;
    int  systems    = 0;
    int  cycles     = 0;
    int  hold_left  = 0;
    bit  calm       = 1'b0;
    bit  hold_req   = 1'b0;
    bit  hold_done  = 1'b0;

    lower_bidiagonal_forward_solve_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // x = (rhs * 2^F - sub * x_prev) / diag, truncated, saturated
    function automatic t_out_word solve_row(input t_in_word w,
                                            input logic signed [DATA_WIDTH-1:0] xp);
        logic signed [NUM_W+1:0] numer;
        logic signed [NUM_W+1:0] dvs;
        logic signed [NUM_W+1:0] quot;
        t_out_word               r;
        r.zero_divisor = 1'b0;
        r.saturated    = 1'b0;
        r.last_out     = w.last_row;
        numer = $signed(w.rhs);
        numer = numer <<< FRAC_BITS;
        if (!w.first_row) begin
            numer = numer - $signed(w.sub_diag) * $signed(xp);
        end
        if (w.diag == '0) begin
            r.zero_divisor = 1'b1;
            r.saturated    = 1'b1;
            r.solution     = (numer < 0) ? W_MIN : W_MAX;
        end else begin
            dvs  = $signed(w.diag);
            quot = numer / dvs;
            if (quot > Q_MAX) begin
                r.saturated = 1'b1;
                r.solution  = W_MAX;
            end else if (quot < Q_MIN) begin
                r.saturated = 1'b1;
                r.solution  = W_MIN;
            end else begin
                r.solution = quot[DATA_WIDTH-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_table_row mk(input logic [DATA_WIDTH-1:0] d, s, r,
                                      input bit f, l, input bit typed = 1'b0,
                                      input logic [DATA_WIDTH-1:0] sol = '0,
                                      input bit z = 1'b0, input bit sat = 1'b0);
        t_table_row row;
        row.w.diag             = d;
        row.w.sub_diag         = s;
        row.w.rhs              = r;
        row.w.first_row        = f;
        row.w.last_row         = l;
        row.typed              = typed;
        row.sol.solution       = sol;
        row.sol.zero_divisor   = z;
        row.sol.saturated      = sat;
        row.sol.last_out       = l;
        return row;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_entry();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            case ($urandom_range(0, 5))
                0: return '0;
                1: return W_MAX;
                2: return W_MIN;
                3: return 32'h0000_0001;
                4: return '1;
                default: return 32'hffff_0000;
            endcase
        end
        if (sel < 25) return $urandom;
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_diag();
        int unsigned             sel;
        logic [DATA_WIDTH-1:0]   mag;
        sel = $urandom_range(0, 99);
        if (sel < 3) return '0;
        if (sel < 20) return rand_entry();
        mag = $urandom_range(32'h0000_8000, 32'h0004_0000);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic offer_row(input t_in_word w, input bit typed, input t_out_word typed_sol);
        t_out_word pred;
        calm <= (rows_sent >= 600 && rows_sent < 800);
        if (rows_sent >= 300) hold_req <= 1'b1;
        while (!calm && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred   = solve_row(w, x_prev);
        x_prev = pred.solution;
        sol_q.push_back(typed ? typed_sol : pred);
        rows_sent++;
    endtask

    // output side: random stalls, one long hold-off, a calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_ready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sol_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected solution word sol=%h zdiv=%b sat=%b last=%b",
                             o_data.solution, o_data.zero_divisor, o_data.saturated,
                             o_data.last_out);
            end else begin
                want = sol_q.pop_front();
                if (o_data.zero_divisor) zdiv_seen++;
                if (o_data.saturated) sat_seen++;
                if (o_data.solution !== want.solution ||
                    o_data.zero_divisor !== want.zero_divisor ||
                    o_data.saturated !== want.saturated ||
                    o_data.last_out !== want.last_out) begin
                    errors++;
                    if (errors <= 10)
                        $display({"word %0d mismatch: exp sol=%h zdiv=%b sat=%b last=%b,",
                                  " got sol=%h zdiv=%b sat=%b last=%b"},
                                 checked, want.solution, want.zero_divisor,
                                 want.saturated, want.last_out, o_data.solution,
                                 o_data.zero_divisor, o_data.saturated, o_data.last_out);
                end
                checked++;
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        t_table_row rows[$];
        t_in_word   w;
        t_out_word  none;
        int         sys_len;
        int         dir_n;
        bit         broken;

        none = '0;
        rows.push_back(mk(ONE, 32'h0005_0000, 32'h0002_0000, 0, 0, 1, 32'h0002_0000));
        rows.push_back(mk(32'h0002_0000, W_MAX, 32'h0003_0000, 1, 0, 1, 32'h0001_8000));
        rows.push_back(mk(ONE, ONE, 32'h0002_0000, 0, 0, 1, 32'h0000_8000));
        rows.push_back(mk('0, ONE, 32'h0003_0000, 1, 0, 1, W_MAX, 1, 1));
        rows.push_back(mk('0, ONE, 32'hfffd_0000, 1, 0, 1, W_MIN, 1, 1));
        rows.push_back(mk('0, '0, '0, 1, 1, 1, W_MAX, 1, 1));
        rows.push_back(mk(32'h0000_0001, '0, W_MAX, 1, 0, 1, W_MAX, 0, 1));
        rows.push_back(mk(32'h0000_0001, '0, W_MIN, 1, 0, 1, W_MIN, 0, 1));
        rows.push_back(mk('1, '0, W_MAX, 1, 0, 1, W_MIN, 0, 1));
        rows.push_back(mk(32'h0003_0000, '0, 32'h0000_0001, 1, 0, 1, '0));
        rows.push_back(mk(32'h0003_0000, '0, '1, 1, 0, 1, '0));
        rows.push_back(mk(W_MIN, W_MAX, W_MIN, 1, 0, 1, ONE));
        rows.push_back(mk(W_MAX, W_MAX, W_MAX, 0, 0));
        rows.push_back(mk(W_MIN, W_MIN, W_MIN, 0, 1));
        rows.push_back(mk(ONE, '0, 32'hfff8_c000, 1, 1, 1, 32'hfff8_c000));
        rows.push_back(mk(32'h0000_8000, 32'hfffe_0000, ONE, 0, 0));
        rows.push_back(mk('0, 32'h0002_0000, '0, 0, 0));
        rows.push_back(mk(W_MAX, '0, '0, 0, 1, 1, '0));
        rows.push_back(mk(32'h0000_4000, 32'h8000_0001, 32'h7fff_0000, 0, 0));
        rows.push_back(mk(32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f, 1, 1));
        dir_n = rows.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) offer_row(rows[k].w, rows[k].typed, rows[k].sol);

        while (rows_sent < dir_n + RAND_ROWS) begin
            if ($urandom_range(0, 9) == 0) begin
                w.diag      = rand_diag();
                w.sub_diag  = rand_entry();
                w.rhs       = rand_entry();
                w.first_row = $urandom_range(0, 1);
                w.last_row  = $urandom_range(0, 1);
                offer_row(w, 1'b0, none);
            end else begin
                sys_len = $urandom_range(1, 12);
                broken  = ($urandom_range(0, 19) == 0);
                systems++;
                for (int k = 0; k < sys_len; k++) begin
                    w.diag      = rand_diag();
                    w.sub_diag  = rand_entry();
                    w.rhs       = rand_entry();
                    w.first_row = (k == 0) && !broken;
                    w.last_row  = (k == sys_len - 1);
                    offer_row(w, 1'b0, none);
                end
            end
        end
        i_valid <= 1'b0;

        while (sol_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Solved %0d rows (%0d from the table, %0d random systems), %0d words checked.",
                 rows_sent, dir_n, systems, checked);
        $display("Zero divisors seen: %0d, saturated solutions seen: %0d, mismatches: %0d.",
                 zdiv_seen, sat_seen, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/lbfs_pkg.sv
sv/lbfs_mul.sv
sv/lbfs_div.sv
sv/lower_bidiagonal_forward_solve_core.sv
tb/lower_bidiagonal_forward_solve_core_test.sv
